// File: design/sts_pkg.sv
// Package for the stereo transient shaper: types, register indexes, constants.
// No dependencies.
`default_nettype none
package sts_pkg;
  localparam int unsigned CoeffBits = 16;
  localparam int unsigned RegCount  = 7;
  localparam int unsigned RegIdxBits = 3;

  typedef enum logic [RegIdxBits-1:0] {
    REG_FAST_ATK = 3'd0,
    REG_FAST_REL = 3'd1,
    REG_SLOW_ATK = 3'd2,
    REG_SLOW_REL = 3'd3,
    REG_SMOOTH   = 3'd4,
    REG_ATK_GAIN = 3'd5,
    REG_SUS_GAIN = 3'd6
  } reg_idx_t;

  localparam logic [CoeffBits-1:0] RstFastAtk = 16'd64857;
  localparam logic [CoeffBits-1:0] RstFastRel = 16'd65468;
  localparam logic [CoeffBits-1:0] RstSlowAtk = 16'd65468;
  localparam logic [CoeffBits-1:0] RstSlowRel = 16'd65529;
  localparam logic [CoeffBits-1:0] RstSmooth  = 16'd64185;
  localparam logic [CoeffBits-1:0] RstGain    = 16'd4096;

  typedef struct packed {
    logic [CoeffBits-1:0] fast_atk;
    logic [CoeffBits-1:0] fast_rel;
    logic [CoeffBits-1:0] slow_atk;
    logic [CoeffBits-1:0] slow_rel;
    logic [CoeffBits-1:0] smooth;
    logic [CoeffBits-1:0] atk_gain;
    logic [CoeffBits-1:0] sus_gain;
  } regs_t;

  // datapath operation codes
  typedef enum logic [2:0] {
    OP_MAG    = 3'd0,  // load sample, magnitude
    OP_FAST   = 3'd1,  // fast follower
    OP_SLOW   = 3'd2,  // slow follower
    OP_DIVINI = 3'd3,  // set up weight division
    OP_DIVSTP = 3'd4,  // one quotient bit
    OP_TARGET = 3'd5,  // target gain
    OP_SMOOTH = 3'd6,  // gain smoother
    OP_SCALE  = 3'd7   // output scaling
  } op_t;

  typedef struct packed {
    logic en;
    op_t  op;
    logic chan;   // 0 left, 1 right
  } dp_cmd_t;

  localparam int unsigned WeightBits = 16;
endpackage
`default_nettype wire

// File: design/sts_if.sv
// Valid/ready channel interfaces for the shaper: sample, result, config.
// Depends on nothing.
`default_nettype none
interface sts_sample_if #(parameter int SAMPLE_BITS = 24);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic block_end;
  modport source (output valid, left_in, right_in, block_end, input ready);
  modport sink (input valid, left_in, right_in, block_end, output ready);
endinterface

interface sts_result_if #(parameter int SAMPLE_BITS = 24);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic block_end_out;
  modport source (output valid, left_out, right_out, block_end_out, input ready);
  modport sink (input valid, left_out, right_out, block_end_out, output ready);
endinterface

interface sts_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/sts_ctrl.sv
// Controller state machine of the shaper: sequences datapath operations per item.
// Depends on sts_pkg.
`default_nettype none
module sts_ctrl
  import sts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic         load,
  output logic         done_store,
  output dp_cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_TAIL = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [1:0] step, step_next;   // position in the fixed op list
  logic [4:0] bitc, bitc_next;
  logic chan, chan_next;
  logic out_valid_next;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign load = in_valid && in_ready;

  always_comb begin
    state_next = state;
    step_next = step;
    bitc_next = bitc;
    chan_next = chan;
    out_valid_next = out_valid && !out_ready;
    done_store = 1'b0;
    cmd = '{en: 1'b0, op: OP_MAG, chan: chan};
    unique case (state)
      S_IDLE: begin
        if (load) begin
          state_next = S_RUN;
          step_next = 2'd0;
          chan_next = 1'b0;
        end
      end
      S_RUN: begin
        cmd.en = 1'b1;
        unique case (step)
          2'd0: cmd.op = OP_MAG;
          2'd1: cmd.op = OP_FAST;
          2'd2: cmd.op = OP_SLOW;
          default: cmd.op = OP_DIVINI;
        endcase
        step_next = step + 2'd1;
        if (step == 2'd3) begin
          state_next = S_DIV;
          bitc_next = 5'd0;
        end
      end
      S_DIV: begin
        cmd.en = 1'b1;
        cmd.op = OP_DIVSTP;
        bitc_next = bitc + 5'd1;
        if (bitc == 5'd15) begin
          state_next = S_TAIL;
          step_next = 2'd0;
        end
      end
      S_TAIL: begin
        cmd.en = 1'b1;
        unique case (step)
          2'd0: cmd.op = OP_TARGET;
          2'd1: cmd.op = OP_SMOOTH;
          default: cmd.op = OP_SCALE;
        endcase
        step_next = step + 2'd1;
        if (step == 2'd2) begin
          step_next = 2'd0;
          if (chan) begin
            state_next = S_IDLE;
            done_store = 1'b1;
            out_valid_next = 1'b1;
          end else begin
            chan_next = 1'b1;
            state_next = S_RUN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= 2'd0;
      bitc <= 5'd0;
      chan <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      bitc <= bitc_next;
      chan <= chan_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

// File: design/sts_dp.sv
// Datapath of the shaper: per-channel state, a shared one-pole multiply-add, divider, scaler.
// Depends on sts_pkg.
`default_nettype none
module sts_dp
  import sts_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire regs_t                         regs,
  input  wire logic                          load,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  input  wire logic                          block_end,
  input  wire dp_cmd_t                       cmd,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  output logic                               block_end_out
);
  localparam int MagBits = SAMPLE_BITS + 1;           // |x|+1 up to 2^(N-1)+1
  localparam int PBits = MagBits + CoeffBits + 1;     // one-pole sum width
  localparam int ProdBits = SAMPLE_BITS + CoeffBits + 1;
  localparam int DivBits = MagBits + WeightBits;

  logic signed [SAMPLE_BITS-1:0] smp [2];
  logic [MagBits-1:0] fast [2];
  logic [MagBits-1:0] slow [2];
  logic [CoeffBits-1:0] gain [2];
  logic blk;
  logic [MagBits-1:0] mag;
  logic [DivBits-1:0] rem;
  logic [MagBits:0] dsor;
  logic [WeightBits-1:0] quo;
  logic [CoeffBits-1:0] tgt;
  logic signed [SAMPLE_BITS-1:0] res [2];

  logic signed [SAMPLE_BITS-1:0] x;
  logic [MagBits-1:0] absx;
  logic [CoeffBits-1:0] c;
  logic [MagBits-1:0] prev, inp;
  logic [PBits-1:0] pole_sum;
  logic [CoeffBits:0] onemc;
  logic [DivBits:0] trial;
  logic [DivBits-1:0] rem_sh;
  logic signed [ProdBits-1:0] prod;
  logic signed [ProdBits-13:0] q;
  logic signed [ProdBits-13:0] hi, lo;

  assign x = smp[cmd.chan];
  assign absx = x[SAMPLE_BITS-1] ? MagBits'(-$signed({x[SAMPLE_BITS-1], x}))
                                 : MagBits'($unsigned(x));
  assign hi = (ProdBits-12)'((1 <<< (SAMPLE_BITS-1)) - 1);
  assign lo = -hi - (ProdBits-12)'(1);

  // shared one-pole: (c*prev + (1-c)*inp + half) >> 16
  always_comb begin
    c = regs.smooth;
    prev = MagBits'(gain[cmd.chan]);
    inp = MagBits'(tgt);
    unique case (cmd.op)
      OP_FAST: begin
        prev = fast[cmd.chan];
        inp = mag;
        c = (mag > prev) ? regs.fast_atk : regs.fast_rel;
      end
      OP_SLOW: begin
        prev = slow[cmd.chan];
        inp = mag;
        c = (mag > prev) ? regs.slow_atk : regs.slow_rel;
      end
      OP_TARGET: begin
        prev = MagBits'(regs.atk_gain);
        inp = MagBits'(regs.sus_gain);
        c = quo;
      end
      default: ;
    endcase
    onemc = 17'h10000 - {1'b0, c};
    pole_sum = PBits'(c) * PBits'(prev) + PBits'(onemc) * PBits'(inp)
               + PBits'(17'h08000);
  end

  assign rem_sh = {rem[DivBits-2:0], 1'b0};
  assign trial = {1'b0, rem_sh} - (DivBits+1)'(dsor);
  assign prod = ProdBits'(x) * $signed({1'b0, gain[cmd.chan]}) + ProdBits'(2048);
  assign q = prod[ProdBits-1:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        fast[i] <= '0;
        slow[i] <= '0;
        gain[i] <= RstGain;
      end
    end else if (cmd.en) begin
      unique case (cmd.op)
        OP_FAST: fast[cmd.chan] <= pole_sum[MagBits+15:16];
        OP_SLOW: slow[cmd.chan] <= pole_sum[MagBits+15:16];
        OP_SMOOTH: gain[cmd.chan] <= pole_sum[31:16];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      smp[0] <= left_in;
      smp[1] <= right_in;
      blk <= block_end;
    end
    if (cmd.en) begin
      unique case (cmd.op)
        OP_MAG: mag <= absx + MagBits'(1);
        OP_DIVINI: begin
          // numerator (fast-slow)<<16 shifted in MSB-first from rem top
          dsor <= {1'b0, fast[cmd.chan]} + (MagBits+1)'(1);
          rem <= (fast[cmd.chan] > slow[cmd.chan])
                 ? DivBits'(fast[cmd.chan] - slow[cmd.chan]) : '0;
          quo <= '0;
        end
        OP_DIVSTP: begin
          if (!trial[DivBits]) begin
            rem <= trial[DivBits-1:0];
            quo <= {quo[WeightBits-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[WeightBits-2:0], 1'b0};
          end
        end
        OP_TARGET: tgt <= pole_sum[31:16];
        OP_SCALE: begin
          if (q > hi) res[cmd.chan] <= hi[SAMPLE_BITS-1:0];
          else if (q < lo) res[cmd.chan] <= lo[SAMPLE_BITS-1:0];
          else res[cmd.chan] <= q[SAMPLE_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  assign left_out = res[0];
  assign right_out = res[1];
  assign block_end_out = blk;
endmodule
`default_nettype wire

// File: design/stereo_transient_shaper_unit.sv
// Top level of the stereo transient shaper: config registers, controller, datapath.
// Depends on sts_pkg, sts_if, sts_ctrl, sts_dp.
//
// channel   dir  handshake     payload
// smp       in   valid/ready   left_in, right_in, block_end
// res       out  valid/ready   left_out, right_out, block_end_out
// cfg       in   valid/ready   index (0..6), data (16 bit)
//
// An item takes 23 steps per channel from acceptance to result, being
// magnitude, two follower updates, divide set-up, a 16-step restoring divide for
// the attack weight, target blend, gain smoothing and output scaling, all sequenced
// on one shared datapath. A new item is taken once the previous result has left the
// output register, so the block takes no new pair while one is still in work.
// Reset (synchronous) restores register defaults, zero levels and unity gain.
`default_nettype none
module stereo_transient_shaper_unit
  import sts_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  sts_sample_if.sink smp,
  sts_result_if.source res,
  sts_cfg_if.sink cfg
);
  regs_t regs;
  dp_cmd_t cmd;
  logic load;
  logic done_store;
  logic out_valid;

  assign cfg.ready = 1'b1;

  // configuration bank; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{RstFastAtk, RstFastRel, RstSlowAtk, RstSlowRel, RstSmooth,
                RstGain, RstGain};
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FAST_ATK: regs.fast_atk <= cfg.data;
        REG_FAST_REL: regs.fast_rel <= cfg.data;
        REG_SLOW_ATK: regs.slow_atk <= cfg.data;
        REG_SLOW_REL: regs.slow_rel <= cfg.data;
        REG_SMOOTH:   regs.smooth <= cfg.data;
        REG_ATK_GAIN: regs.atk_gain <= cfg.data;
        REG_SUS_GAIN: regs.sus_gain <= cfg.data;
        default: ;
      endcase
    end
  end

  sts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(smp.valid), .in_ready(smp.ready),
    .out_valid(out_valid), .out_ready(res.ready),
    .load(load), .done_store(done_store), .cmd(cmd)
  );

  sts_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .regs(regs), .load(load),
    .left_in(smp.left_in), .right_in(smp.right_in), .block_end(smp.block_end),
    .cmd(cmd),
    .left_out(res.left_out), .right_out(res.right_out),
    .block_end_out(res.block_end_out)
  );

  // done_store marks the last scaling step; result valid rises in the cycle after it
  assign res.valid = out_valid && !done_store;
endmodule
`default_nettype wire

// File: design/sts_checker.sv
// Port-level checker for the shaper, bound to the top level.
// Depends on sts_if and stereo_transient_shaper_unit.
`default_nettype none
module sts_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cfg_ready
);
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("item taken with result pending");
  a_no_quick_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("config stalled");
endmodule

bind stereo_transient_shaper_unit sts_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(smp.valid), .in_ready(smp.ready),
  .out_valid(res.valid), .out_ready(res.ready), .cfg_ready(cfg.ready)
);
`default_nettype wire

// File: bench/stereo_transient_shaper_unit_tb.sv
// Self-checking bench for the stereo transient shaper: drives sample pairs and
// register writes, predicts each shaped pair and compares it with the output.
// Depends on sts_pkg, sts_if and the stereo_transient_shaper_unit RTL.
`default_nettype none
module stereo_transient_shaper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam int SB = 24;
  localparam longint SMAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sts_sample_if #(.SAMPLE_BITS(SB)) smp ();
  sts_result_if #(.SAMPLE_BITS(SB)) res ();
  sts_cfg_if cfg ();

  stereo_transient_shaper_unit #(.SAMPLE_BITS(SB)) DUT (
    .clk(clk), .rst(rst), .smp(smp.sink), .res(res.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shaped pair as it should leave the block.
  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 bend;
  } shaped_t;

  // Predictor state: register copy, follower levels and smoothed gains.
  logic [15:0]  shadow_regs [RegCount];
  longint unsigned fast_lvl [2];
  longint unsigned slow_lvl [2];
  longint unsigned gain_q12 [2];

  shaped_t shaped_q[$];
  int     errors;
  int     sent;
  int     received;
  int     src_idle_pct;
  int     snk_stall_pct;
  int     holdoff_cycles;

  // --- predictor ----------------------------------------------------------
  function automatic longint unsigned pole(longint unsigned c, longint unsigned prev,
                                           longint unsigned x);
    return (c * prev + (65536 - c) * x + 32768) >> 16;
  endfunction

  function automatic logic [SB-1:0] shape_channel(int ch, longint x);
    longint unsigned mag, w, tgt;
    longint p, q;
    mag = ((x < 0) ? -x : x) + 1;
    fast_lvl[ch] = pole(mag > fast_lvl[ch] ? shadow_regs[REG_FAST_ATK]
                        : shadow_regs[REG_FAST_REL], fast_lvl[ch], mag);
    slow_lvl[ch] = pole(mag > slow_lvl[ch] ? shadow_regs[REG_SLOW_ATK]
                        : shadow_regs[REG_SLOW_REL], slow_lvl[ch], mag);
    w = 0;
    if (fast_lvl[ch] > slow_lvl[ch]) begin
      w = ((fast_lvl[ch] - slow_lvl[ch]) << 16) / (fast_lvl[ch] + 1);
      if (w > 65535) w = 65535;
    end
    tgt = (longint'(shadow_regs[REG_ATK_GAIN]) * w
           + longint'(shadow_regs[REG_SUS_GAIN]) * (65536 - w) + 32768) >> 16;
    gain_q12[ch] = pole(shadow_regs[REG_SMOOTH], gain_q12[ch], tgt) & 64'hFFFF;
    p = x * longint'(gain_q12[ch]) + 2048;
    q = p >>> 12;  // arithmetic shift is floor division
    if (q > SMAX) q = SMAX;
    if (q < SMIN) q = SMIN;
    return q[SB-1:0];
  endfunction

  function automatic void predictor_reset();
    shadow_regs[REG_FAST_ATK] = RstFastAtk;
    shadow_regs[REG_FAST_REL] = RstFastRel;
    shadow_regs[REG_SLOW_ATK] = RstSlowAtk;
    shadow_regs[REG_SLOW_REL] = RstSlowRel;
    shadow_regs[REG_SMOOTH]   = RstSmooth;
    shadow_regs[REG_ATK_GAIN] = RstGain;
    shadow_regs[REG_SUS_GAIN] = RstGain;
    for (int c = 0; c < 2; c++) begin
      fast_lvl[c] = 0;
      slow_lvl[c] = 0;
      gain_q12[c] = 4096;
    end
  endfunction

  // --- drivers ------------------------------------------------------------
  // Offers one pair, idling first at the sender rate; returns once accepted,
  // leaving valid up so a following pair can go straight on.
  task automatic send_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r, logic be);
    shaped_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid    <= 1'b1;
    smp.left_in  <= l;
    smp.right_in <= r;
    smp.block_end <= be;
    do @(posedge clk); while (!smp.ready);
    e.left  = shape_channel(0, longint'(l));
    e.right = shape_channel(1, longint'(r));
    e.bend  = be;
    shaped_q.push_back(e);
    sent++;
  endtask

  // Wait for the block to drain; registers are only touched while idle.
  task automatic drain();
    smp.valid <= 1'b0;
    while (shaped_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    shadow_regs[idx] = val;
  endtask

  task automatic write_all(logic [15:0] fa, logic [15:0] fr, logic [15:0] sa,
                           logic [15:0] sr, logic [15:0] sm, logic [15:0] ag,
                           logic [15:0] sg);
    drain();
    write_reg(REG_FAST_ATK, fa);
    write_reg(REG_FAST_REL, fr);
    write_reg(REG_SLOW_ATK, sa);
    write_reg(REG_SLOW_REL, sr);
    write_reg(REG_SMOOTH, sm);
    write_reg(REG_ATK_GAIN, ag);
    write_reg(REG_SUS_GAIN, sg);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(5))
      0: return SB'($urandom_range(255));
      1: return -SB'($urandom_range(256));
      2: return $urandom_range(1) ? SB'(SMAX) : SB'(SMIN);
      default: return SB'($urandom);
    endcase
  endfunction

  // --- long receiver hold-off ---------------------------------------------
  always @(posedge clk) begin
    if (holdoff_cycles > 0) holdoff_cycles <= holdoff_cycles - 1;
  end

  // --- checker ------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if ($urandom_range(99) < snk_stall_pct || holdoff_cycles > 0)
        res.ready <= 1'b0;
      else
        res.ready <= 1'b1;
      if (res.valid && res.ready) begin
        received++;
        if (shaped_q.size() == 0) begin
          $error("unexpected result left=%0d right=%0d", res.left_out, res.right_out);
          errors++;
        end else begin
          shaped_t e;
          e = shaped_q.pop_front();
          if (res.left_out !== e.left) begin
            $error("left_out expected %0d got %0d", e.left, res.left_out);
            errors++;
          end
          if (res.right_out !== e.right) begin
            $error("right_out expected %0d got %0d", e.right, res.right_out);
            errors++;
          end
          if (res.block_end_out !== e.bend) begin
            $error("block_end_out expected %0b got %0b", e.bend, res.block_end_out);
            errors++;
          end
        end
      end
    end
  end

  // --- tests --------------------------------------------------------------
  task automatic test_directed_extremes();
    // full-scale, zero, one LSB, and every bit toggled in both channels
    send_pair(SB'(SMAX), SB'(SMIN), 1'b0);
    send_pair(SB'(SMIN), SB'(SMAX), 1'b1);
    send_pair('0, '0, 1'b0);
    send_pair(SB'(1), SB'(-1), 1'b1);
    send_pair(24'h555555, 24'hAAAAAA, 1'b0);
    send_pair(24'hAAAAAA, 24'h555555, 1'b1);
    for (int i = 0; i < 4; i++) send_pair(SB'(SMIN), SB'(SMIN), 1'b0);
    for (int i = 0; i < 4; i++) send_pair(SB'(3), SB'(-3), 1'b0);
  endtask

  task automatic test_zero_poles_and_saturation();
    // zero poles make followers jump; max gain forces saturation
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_pair(SB'(SMAX), SB'(SMIN), 1'b0);
    send_pair(SB'(1000), SB'(-1000), 1'b1);
    send_pair(SB'(1), SB'(-1), 1'b0);
    // out-of-range and minimum gains, slowest poles
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
    send_pair(SB'(SMAX), SB'(SMIN), 1'b1);
    send_pair(SB'(SMAX), SB'(SMIN), 1'b0);
    // bursts into silence with a strong attack gain
    write_all(16'd40000, 16'd65000, 16'd65400, 16'd65530, 16'd30000, 16'd64917, 16'd258);
    for (int i = 0; i < 3; i++) send_pair(SB'(SMAX), SB'(SMIN), 1'b0);
    send_pair('0, '0, 1'b1);
  endtask

  // Random pairs under a given sender-idle and receiver-stall mix; transients are shaped as bursts.
  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    logic signed [SB-1:0] l, r;
    int burst;
    int n;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    n = 0;
    while (n < count) begin
      if ($urandom_range(7) == 0) begin
        l = rand_sample();
        r = rand_sample();
        burst = int'($urandom_range(6, 1));
        repeat (burst) send_pair(l, r, 1'($urandom_range(1)));
        n += burst;
      end else begin
        send_pair(rand_sample(), rand_sample(), 1'($urandom_range(1)));
        n++;
      end
    end
  endtask

  task automatic test_random_settings();
    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom_range(64917, 258)),
              16'($urandom_range(64917, 258)));
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering items
    drain();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    holdoff_cycles <= 300;
    for (int i = 0; i < 20; i++) send_pair(rand_sample(), rand_sample(), 1'b0);
  endtask

  // --- sequence -----------------------------------------------------------
  initial begin
    errors = 0; sent = 0; received = 0;
    src_idle_pct = 0; snk_stall_pct = 0; holdoff_cycles = 0;
    smp.valid = 1'b0; smp.left_in = '0; smp.right_in = '0; smp.block_end = 1'b0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    res.ready = 1'b0;
    predictor_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_zero_poles_and_saturation();
    test_random_settings();
    test_random_traffic(400, 0, 0);
    test_random_settings();
    test_random_traffic(350, 54, 0);
    test_backpressure();
    test_random_settings();
    test_random_traffic(350, 0, 54);
    write_all(RstFastAtk, RstFastRel, RstSlowAtk, RstSlowRel, RstSmooth, RstGain, 16'd8192);
    test_random_traffic(400, 13, 13);

    drain();
    $display("Shaped %0d stereo pairs (%0d checked) across register extremes, random",
             sent, received);
    $display("settings, bursts and idle/stall/back-pressure mixes.");
    if (errors == 0)
      $display("stereo_transient_shaper_unit verification clean");
    else
      $display("stereo_transient_shaper_unit verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("stereo_transient_shaper_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire
